[hw/rtl/instruction_window_retire_core_macros.svh]
// ----------------------------------------------------------------------------
// Instruction window retire core: assertion macros
// Shared wrappers so that every check uses the same clock and edge.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_WINDOW_RETIRE_CORE_MACROS_SVH
`define INSTRUCTION_WINDOW_RETIRE_CORE_MACROS_SVH

// Check on the rising clock edge, switched off while reset is asserted.
`define IWR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on the rising clock edge, also active during reset.
`define IWR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/iwr_pkg.sv]
// ----------------------------------------------------------------------------
// Instruction window retire package
// Command and status codes, decoded operations and the request format
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package iwr_pkg;

  // Default ring depth of the window
  localparam int unsigned WINDOW_DEPTH = 64;

  // Depth of the request queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Most entries freed per retire tick, and retire width after reset
  localparam logic [3:0] MAX_RETIRE       = 4'd8;
  localparam logic [3:0] RETIRE_WIDTH_RST = 4'd4;

  // Command codes on the input channel
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_COMPLETE = 2'd1;
  localparam logic [1:0] CMD_RETIRE   = 2'd2;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_COMPLETE,
    OP_RETIRE,
    OP_NOP
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ALREADY = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  // Classified request held in the queue
  typedef struct packed {
    op_e         op;
    logic [31:0] tag;
    logic [2:0]  mem_ops;
  } iwr_req_t;

endpackage

[hw/rtl/iwr_front.sv]
// ----------------------------------------------------------------------------
// Instruction window retire front end
// Accepts requests, decodes the command and buffers them in a short queue.
// ----------------------------------------------------------------------------
module iwr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [31:0]      instr_tag_i,
  input  logic [2:0]       mem_ops_i,
  output logic             req_valid_o,
  output iwr_pkg::iwr_req_t req_o,
  input  logic             req_pop_i
);
  import iwr_pkg::*;

  localparam int unsigned QIdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCntW = $clog2(QUEUE_DEPTH + 1);

  iwr_req_t              slot_q [QUEUE_DEPTH];
  logic [QIdxW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]      cnt_q, cnt_d;
  iwr_req_t              dec_req;
  logic                  push, pop;

  // Classify the incoming command
  always_comb begin
    dec_req.tag     = instr_tag_i;
    dec_req.mem_ops = mem_ops_i;
    unique case (cmd_i)
      CMD_INSERT:   dec_req.op = OP_INSERT;
      CMD_COMPLETE: dec_req.op = OP_COMPLETE;
      CMD_RETIRE:   dec_req.op = OP_RETIRE;
      default:      dec_req.op = OP_NOP;
    endcase
  end

  // Queue handshake
  assign in_stall_o  = (cnt_q == QCntW'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = slot_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QIdxW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QIdxW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QIdxW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QIdxW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec_req;
    end
  end

endmodule

[hw/rtl/iwr_back.sv]
// ----------------------------------------------------------------------------
// Instruction window retire back end
// Holds the window ring in a memory with one write and one read port, runs
// insert, completion search and retire walk, and keeps the registered result.
// ----------------------------------------------------------------------------
module iwr_back #(
  parameter int unsigned WindowDepth = iwr_pkg::WINDOW_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  iwr_pkg::iwr_req_t req_i,
  output logic              req_pop_o,
  input  logic [3:0]        retire_width_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [3:0]        retired_count_o,
  output logic [6:0]        occupancy_o
);
  import iwr_pkg::*;

  localparam int unsigned PtrW = $clog2(WindowDepth);
  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  typedef struct packed {
    logic [31:0] tag;
    logic [2:0]  pending;
  } entry_t;

  // Window memory
  entry_t          entry_q [WindowDepth];
  entry_t          rd_data_q;
  logic [PtrW-1:0] rd_idx_q;
  logic            rd_vld_q, rd_vld_d;
  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  // Window and scan state
  back_state_e     state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [PtrW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic [CntW-1:0] limit_q, limit_d;
  logic [3:0]      done_q, done_d;
  logic [31:0]     tag_q, tag_d;
  op_e             op_q, op_d;

  // Result register
  logic            res_vld_q, res_vld_d;
  status_e         res_status_q, res_status_d;
  logic [3:0]      res_retired_q, res_retired_d;
  logic [6:0]      res_occ_q;
  logic            res_load;

  logic            res_free, start, is_full, scan_end;
  logic [3:0]      rw_eff;
  logic [CmpW-1:0] rw_cmp, fill_cmp;

  assign res_free  = !res_vld_q || !out_stall_i;
  assign start     = (state_q == BK_IDLE) && req_valid_i && res_free;
  assign req_pop_o = start;
  assign is_full   = (fill_q == CntW'(WindowDepth));

  // Effective retire limit: width clamped to eight, bounded by the fill
  assign rw_eff   = (retire_width_i > MAX_RETIRE) ? MAX_RETIRE : retire_width_i;
  assign rw_cmp   = CmpW'(rw_eff);
  assign fill_cmp = CmpW'(fill_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start && (req_i.op == OP_COMPLETE || req_i.op == OP_RETIRE)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    fill_d        = fill_q;
    scan_ptr_d    = scan_ptr_q;
    issue_d       = issue_q;
    limit_d       = limit_q;
    done_d        = done_q;
    tag_d         = tag_q;
    op_d          = op_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = head_q;
    mem_raddr     = scan_ptr_q;
    mem_wdata     = {req_i.tag, req_i.mem_ops};
    res_load      = 1'b0;
    res_status_d  = ST_OK;
    res_retired_d = '0;
    scan_end      = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          op_d       = req_i.op;
          tag_d      = req_i.tag;
          scan_ptr_d = tail_q;
          issue_d    = '0;
          done_d     = '0;
          case (req_i.op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                head_d = (head_q == PtrW'(WindowDepth - 1)) ? '0 : head_q + PtrW'(1);
                fill_d = fill_q + CntW'(1);
              end
            end
            OP_COMPLETE: limit_d = fill_q;
            OP_RETIRE:   limit_d = CntW'((rw_cmp < fill_cmp) ? rw_cmp : fill_cmp);
            default:     res_load = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        if (rd_vld_q) begin
          // Check the entry read in the previous cycle
          if (op_q == OP_COMPLETE) begin
            if (rd_data_q.tag == tag_q) begin
              scan_end = 1'b1;
              res_load = 1'b1;
              if (rd_data_q.pending == 3'd0) begin
                res_status_d = ST_ALREADY;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_q;
                mem_wdata = {rd_data_q.tag, 3'(rd_data_q.pending - 3'd1)};
              end
            end
          end else if (rd_data_q.pending != 3'd0) begin
            // Oldest entry still waits on memory: retirement stops
            scan_end      = 1'b1;
            res_load      = 1'b1;
            res_retired_d = done_q;
          end else begin
            done_d = done_q + 4'd1;
            tail_d = (tail_q == PtrW'(WindowDepth - 1)) ? '0 : tail_q + PtrW'(1);
            fill_d = fill_q - CntW'(1);
          end
        end else if (issue_q == limit_q) begin
          // Every entry in range checked
          scan_end = 1'b1;
          res_load = 1'b1;
          if (op_q == OP_COMPLETE) begin
            res_status_d = ST_MISSING;
          end else begin
            res_retired_d = done_q;
          end
        end
        // Issue the next read
        if (!scan_end && issue_q < limit_q) begin
          mem_re     = 1'b1;
          scan_ptr_d = (scan_ptr_q == PtrW'(WindowDepth - 1)) ? '0 :
                       scan_ptr_q + PtrW'(1);
          issue_d    = issue_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  assign rd_vld_d = mem_re;

  // Result handshake
  always_comb begin
    if (res_load) begin
      res_vld_d = 1'b1;
    end else begin
      res_vld_d = res_vld_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      scan_ptr_q <= '0;
      issue_q    <= '0;
      limit_q    <= '0;
      done_q     <= '0;
      op_q       <= OP_NOP;
      rd_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      scan_ptr_q <= scan_ptr_d;
      issue_q    <= issue_d;
      limit_q    <= limit_d;
      done_q     <= done_d;
      op_q       <= op_d;
      rd_vld_q   <= rd_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    if (res_load) begin
      res_status_q  <= res_status_d;
      res_retired_q <= res_retired_d;
      res_occ_q     <= 7'(fill_d);
    end
  end

  // Window memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entry_q[mem_raddr];
      rd_idx_q  <= mem_raddr;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign status_o        = res_status_q;
  assign retired_count_o = res_retired_q;
  assign occupancy_o     = res_occ_q;

endmodule

[hw/rtl/instruction_window_retire_core.sv]
// ----------------------------------------------------------------------------
// Instruction window retire core
// In-order instruction window in a ring: insert, memory-op completion and
// retire ticks, one result per request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  request  | in        | in_valid_i / in_stall_o  | cmd_i, instr_tag_i, mem_ops_i
//  result   | out       | out_valid_o / out_stall_i| status_o, retired_count_o,
//           |           |                          | occupancy_o
//  config   | in        | cfg_we_i                 | cfg_wdata_i (retire width)
//
// Insert and unused commands finish in the back end's idle state. A completion
// reads entries from the oldest until one matches its tag or every entry has
// been read; a retire reads at most min(width, fill) entries from the oldest.
// The single read port of the memory paces these scans, one entry a cycle.
// The front queue holds two requests, so input is taken while the back end
// works or a result is stalled until the queue fills.
// Reset empties the window; the memory needs no sweep.
// ----------------------------------------------------------------------------
module instruction_window_retire_core #(
  parameter int unsigned WindowDepth = iwr_pkg::WINDOW_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] instr_tag_i,
  input  logic [2:0]  mem_ops_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  retired_count_o,
  output logic [6:0]  occupancy_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);
  import iwr_pkg::*;

  iwr_req_t   req;
  logic       req_valid, req_pop;
  logic [3:0] retire_width_q;

  // Retire width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retire_width_q <= RETIRE_WIDTH_RST;
    end else if (cfg_we_i) begin
      retire_width_q <= cfg_wdata_i;
    end
  end

  iwr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .instr_tag_i (instr_tag_i),
    .mem_ops_i   (mem_ops_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  iwr_back #(
    .WindowDepth (WindowDepth)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_pop_o       (req_pop),
    .retire_width_i  (retire_width_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .retired_count_o (retired_count_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

[hw/rtl/iwr_checker.sv]
// ----------------------------------------------------------------------------
// Instruction window retire checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "instruction_window_retire_core_macros.svh"

module iwr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [3:0] retired_count_o,
  input logic [6:0] occupancy_o
);
  import iwr_pkg::*;

  // No result is offered while in reset
  `IWR_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

  // A failed request never frees entries
  `IWR_ASSERT(a_err_no_retire, out_valid_o && status_o != ST_OK |-> retired_count_o == 4'd0, "retire with error status")

  // A tick frees at most MAX_RETIRE entries
  `IWR_ASSERT(a_retire_bound, out_valid_o |-> retired_count_o <= MAX_RETIRE, "retired count above limit")

  // A stalled result stays offered and unchanged
  `IWR_ASSERT(a_stall_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(retired_count_o) && $stable(occupancy_o), "stalled result changed")

endmodule

bind instruction_window_retire_core iwr_checker u_iwr_checker (.*);
